>>> sv/bnca_pkg.sv
// Shared types, constants and codes of the batch norm channel affine block.
`default_nettype none
package bnca_pkg;

    localparam int NUM_CHANNELS_DEF = 256;
    localparam int CH_W             = 8;
    localparam int Q_DEPTH          = 4;
    localparam int OUT_DEPTH        = 8;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    localparam logic [31:0] EPS_RST = 32'd168;
    localparam logic [31:0] AVG_RST = 32'h0001_0000;

    typedef enum logic [7:0] {
        CFG_USE_WEIGHT = 8'd0,
        CFG_USE_BIAS   = 8'd1,
        CFG_EPSILON    = 8'd2,
        CFG_AVG_FACTOR = 8'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        FS_IDLE,
        FS_DIV_F,
        FS_MUL_VAR,
        FS_DEN,
        FS_DIV_D,
        FS_SQRT,
        FS_MUL_SCALE,
        FS_MUL_PROD,
        FS_SHIFT,
        FS_WRITE
    } t_fold_st;

    typedef struct packed {
        logic               mode;
        logic [7:0]         channel;
        logic signed [15:0] sample;
        logic signed [15:0] mean;
        logic [31:0]        variance;
        logic signed [15:0] weight;
        logic signed [15:0] bias;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         out_channel;
        logic signed [15:0] result;
        logic               saturated;
    } t_out_item;

    // sample item on its way from front to back
    typedef struct packed {
        logic [7:0]         channel;
        logic signed [15:0] sample;
        logic               in_range;
    } t_smp;

    typedef struct packed {
        logic signed [31:0] scale;
        logic signed [31:0] shift;
    } t_coef;

endpackage
`default_nettype wire

>>> sv/bnca_fifo.sv
// Small register FIFO used for the sample queue and the result queue.
`default_nettype none
module bnca_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire T                           i_data,
    output logic                            o_full,
    output logic                            o_empty,
    input  wire logic                       i_pop,
    output T                                o_data,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;
    logic            s_wr, s_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rd];
    assign s_wr    = i_push && !o_full;
    assign s_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (s_wr) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (s_rd) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            r_cnt <= r_cnt + CW'(s_wr) - CW'(s_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

>>> sv/bnca_front.sv
// Front end: input handshake, item classification, config registers, coefficient folding.
`default_nettype none
module bnca_front #(
    parameter int NUM_CHANNELS = bnca_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire bnca_pkg::t_in_item     i_item,
    output logic                        o_full,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [7:0]             i_cfg_index,
    input  wire logic [31:0]            i_cfg_data,
    input  wire logic                   i_q_full,
    input  wire logic                   i_q_empty,
    output logic                        o_q_push,
    output bnca_pkg::t_smp              o_q_data,
    output logic                        o_wr_en,
    output logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] o_wr_idx,
    output bnca_pkg::t_coef             o_wr_coef
);
    import bnca_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int EXT_W = (IDX_W > CH_W) ? IDX_W : CH_W;
    localparam logic [5:0] DIV_LAST  = 6'd56;
    localparam logic [5:0] SQRT_LAST = 6'd31;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] y;
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            y = 32'sh7FFF_FFFF;
        end else if (x < -64'sh0000_0000_8000_0000) begin
            y = 32'sh8000_0000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    t_fold_st r_st, n_st;

    logic                r_use_w, r_use_b;
    logic [31:0]         r_eps, r_avg;

    logic [IDX_W-1:0]    r_idx;
    logic signed [15:0]  r_mean;
    logic [31:0]         r_var;
    logic signed [16:0]  r_w;
    logic signed [15:0]  r_b;
    logic [32:0]         r_f;
    logic [63:0]         r_p;
    logic [56:0]         r_dnd;
    logic [48:0]         r_rem, r_dvs;
    logic [5:0]          r_cnt;
    logic [63:0]         r_sx, r_sres, r_sbit;
    logic [28:0]         r_inv;
    logic signed [31:0]  r_scale, r_mf, r_shift;
    logic signed [63:0]  r_prod;

    logic                s_acc, s_load, s_in_range;
    logic [EXT_W-1:0]    s_ch_ext;
    logic [49:0]         s_rem_sh;
    logic                s_ge;
    logic [48:0]         s_rem_nx;
    logic [56:0]         s_dnd_nx;
    logic [63:0]         s_sq_t, s_sres_nx;
    logic                s_sq_ge;
    logic [48:0]         s_den;
    logic signed [46:0]  s_m_scale;
    logic signed [49:0]  s_m_mf;
    logic signed [63:0]  s_sh;

    assign o_cfg_ready = 1'b1;
    assign s_ch_ext    = EXT_W'(i_item.channel);
    assign s_in_range  = (32'(i_item.channel) < NUM_CHANNELS);
    assign o_full      = (r_st != FS_IDLE) || i_q_full;
    assign s_acc       = i_push && !o_full;
    assign s_load      = s_acc && (i_item.mode == MODE_LOAD) && s_in_range;
    assign o_q_push    = s_acc && (i_item.mode == MODE_SAMPLE);
    assign o_q_data    = '{channel: i_item.channel, sample: i_item.sample,
                           in_range: s_in_range};

    // restoring divider, one quotient bit per cycle
    assign s_rem_sh = {r_rem, r_dnd[56]};
    assign s_ge     = (s_rem_sh >= {1'b0, r_dvs});
    assign s_rem_nx = s_ge ? 49'(s_rem_sh - {1'b0, r_dvs}) : s_rem_sh[48:0];
    assign s_dnd_nx = {r_dnd[55:0], s_ge};

    // integer square root, one result bit per cycle
    assign s_sq_t    = r_sres + r_sbit;
    assign s_sq_ge   = (r_sx >= s_sq_t);
    assign s_sres_nx = s_sq_ge ? ((r_sres >> 1) + r_sbit) : (r_sres >> 1);

    always_comb begin
        s_den = 49'(r_p[63:16]) + 49'(r_eps);
        if (s_den == '0) begin
            s_den = 49'd1;
        end
    end

    assign s_m_scale = r_w * $signed({1'b0, r_inv});
    assign s_m_mf    = r_mean * $signed({1'b0, r_f});
    assign s_sh      = (64'(r_b) <<< 8) - (r_prod >>> 16);

    assign o_wr_idx  = r_idx;
    assign o_wr_coef = '{scale: r_scale, shift: r_shift};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= FS_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_comb begin
        n_st    = r_st;
        o_wr_en = 1'b0;
        unique case (r_st)
            FS_IDLE: begin
                if (s_load) begin
                    if (!r_use_w && !r_use_b && (r_avg != '0)) begin
                        n_st = FS_DIV_F;
                    end else begin
                        n_st = FS_MUL_VAR;
                    end
                end
            end
            FS_DIV_F:     if (r_cnt == DIV_LAST) n_st = FS_MUL_VAR;
            FS_MUL_VAR:   n_st = FS_DEN;
            FS_DEN:       n_st = FS_DIV_D;
            FS_DIV_D:     if (r_cnt == DIV_LAST) n_st = FS_SQRT;
            FS_SQRT:      if (r_cnt == SQRT_LAST) n_st = FS_MUL_SCALE;
            FS_MUL_SCALE: n_st = FS_MUL_PROD;
            FS_MUL_PROD:  n_st = FS_SHIFT;
            FS_SHIFT:     n_st = FS_WRITE;
            FS_WRITE: begin
                // earlier samples must have read the table first
                if (i_q_empty) begin
                    o_wr_en = 1'b1;
                    n_st    = FS_IDLE;
                end
            end
            default:      n_st = FS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_w <= 1'b0;
            r_use_b <= 1'b0;
            r_eps   <= EPS_RST;
            r_avg   <= AVG_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_USE_WEIGHT: r_use_w <= i_cfg_data[0];
                CFG_USE_BIAS:   r_use_b <= i_cfg_data[0];
                CFG_EPSILON:    r_eps   <= i_cfg_data;
                CFG_AVG_FACTOR: r_avg   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            FS_IDLE: begin
                r_idx  <= s_ch_ext[IDX_W-1:0];
                r_mean <= i_item.mean;
                r_var  <= i_item.variance;
                r_w    <= r_use_w ? 17'(i_item.weight) : 17'sd256;
                r_b    <= r_use_b ? i_item.bias : 16'sd0;
                r_f    <= (!r_use_w && !r_use_b) ? 33'd0 : 33'h0_0001_0000;
                r_dnd  <= 57'(1) << 32;
                r_dvs  <= 49'(r_avg);
                r_rem  <= '0;
                r_cnt  <= '0;
            end
            FS_DIV_F: begin
                r_dnd <= s_dnd_nx;
                r_rem <= s_rem_nx;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == DIV_LAST) begin
                    r_f <= s_dnd_nx[32:0];
                end
            end
            FS_MUL_VAR: begin
                // f is 2^32 only with its low word zero
                r_p <= r_f[32] ? {r_var, 32'd0} : (64'(r_var) * 64'(r_f[31:0]));
            end
            FS_DEN: begin
                r_dnd <= 57'(1) << 56;
                r_dvs <= s_den;
                r_rem <= '0;
                r_cnt <= '0;
            end
            FS_DIV_D: begin
                r_dnd <= s_dnd_nx;
                r_rem <= s_rem_nx;
                if (r_cnt == DIV_LAST) begin
                    r_sx   <= 64'(s_dnd_nx);
                    r_sres <= '0;
                    r_sbit <= 64'(1) << 62;
                    r_cnt  <= '0;
                end else begin
                    r_cnt  <= r_cnt + 6'd1;
                end
            end
            FS_SQRT: begin
                if (s_sq_ge) begin
                    r_sx <= r_sx - s_sq_t;
                end
                r_sres <= s_sres_nx;
                r_sbit <= r_sbit >> 2;
                r_cnt  <= r_cnt + 6'd1;
                if (r_cnt == SQRT_LAST) begin
                    r_inv <= s_sres_nx[28:0];
                end
            end
            FS_MUL_SCALE: begin
                r_scale <= sat32(64'(s_m_scale >>> 8));
                r_mf    <= sat32(64'(s_m_mf >>> 8));
            end
            FS_MUL_PROD: begin
                r_prod <= r_mf * r_scale;
            end
            FS_SHIFT: begin
                r_shift <= sat32(s_sh);
            end
            default: ;
        endcase
    end

    a_no_sample_while_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != FS_IDLE) |-> !o_q_push)
        else $error("sample queued during folding");

    a_write_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |=> (r_st == FS_IDLE))
        else $error("fold did not return to idle after table write");

    a_sqrt_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == FS_SQRT) |-> (r_cnt <= SQRT_LAST))
        else $error("square root step count overrun");

endmodule
`default_nettype wire

>>> sv/bnca_back.sv
// Back end: coefficient table, per-sample affine pipeline and result queue.
`default_nettype none
module bnca_back #(
    parameter int NUM_CHANNELS = bnca_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_q_empty,
    input  wire bnca_pkg::t_smp         i_q_data,
    output logic                        o_q_pop,
    input  wire logic                   i_wr_en,
    input  wire logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] i_wr_idx,
    input  wire bnca_pkg::t_coef        i_wr_coef,
    output logic                        o_empty,
    input  wire logic                   i_pop,
    output bnca_pkg::t_out_item         o_item
);
    import bnca_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int EXT_W = (IDX_W > CH_W) ? IDX_W : CH_W;
    localparam int CW    = $clog2(OUT_DEPTH + 1);

    t_coef              r_mem [NUM_CHANNELS];
    t_coef              r_coef;

    logic               r_va, r_vb;
    t_smp               r_a_smp, r_b_smp;
    logic signed [47:0] r_b_prod;
    logic signed [31:0] r_b_shift;

    logic [EXT_W-1:0]   s_rd_ext;
    logic [CW-1:0]      s_cnt;
    logic               s_out_full, s_c_push;
    logic signed [48:0] s_acc;
    logic signed [32:0] s_q;
    t_out_item          s_out;

    assign s_rd_ext = EXT_W'(i_q_data.channel);
    // in-flight items plus queued results stay within the result queue
    assign o_q_pop  = !i_q_empty &&
                      ((32'(s_cnt) + 32'(r_va) + 32'(r_vb)) < OUT_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_coef;
        end
        if (o_q_pop) begin
            r_coef <= r_mem[s_rd_ext[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= o_q_pop;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_a_smp <= i_q_data;
        end
        if (r_va) begin
            r_b_smp   <= r_a_smp;
            r_b_prod  <= r_a_smp.sample * r_coef.scale;
            r_b_shift <= r_coef.shift;
        end
    end

    assign s_acc    = 49'(r_b_prod) + (49'(r_b_shift) <<< 8);
    assign s_q      = s_acc[48:16];
    assign s_c_push = r_vb;

    always_comb begin
        s_out.out_channel = r_b_smp.channel;
        s_out.saturated   = 1'b0;
        if (!r_b_smp.in_range) begin
            s_out.result = 16'sd0;
        end else if (s_q > 33'sd32767) begin
            s_out.result    = 16'sh7FFF;
            s_out.saturated = 1'b1;
        end else if (s_q < -33'sd32768) begin
            s_out.result    = 16'sh8000;
            s_out.saturated = 1'b1;
        end else begin
            s_out.result = s_q[15:0];
        end
    end

    bnca_fifo #(
        .T     (t_out_item),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_c_push),
        .i_data  (s_out),
        .o_full  (s_out_full),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_data  (o_item),
        .o_count (s_cnt)
    );

    a_no_out_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_c_push && s_out_full))
        else $error("result queue overflow");

    a_pipe_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> ##1 s_c_push)
        else $error("sample lost in pipeline");

endmodule
`default_nettype wire

>>> sv/batch_norm_channel_affine.sv
// Top level of the fixed-point inference batch normalization block.
// Sample items: one per cycle while full is low; the result path is registered.
// Load items: folding, with or without the average-factor divide, uses 57-step
//   divides, a 32-step square root and multiplies; full stays high
//   meanwhile, and the table write waits for queued samples to read the table.
// Reset (synchronous, active low) clears queues, resets config; tables undefined.
`default_nettype none
module batch_norm_channel_affine #(
    parameter int NUM_CHANNELS = bnca_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire bnca_pkg::t_in_item     i_in_item,
    output logic                        o_full,
    output logic                        o_empty,
    input  wire logic                   i_pop,
    output bnca_pkg::t_out_item         o_out_item,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [7:0]             i_cfg_index,
    input  wire logic [31:0]            i_cfg_data
);
    import bnca_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic              s_q_push, s_q_pop, s_q_full, s_q_empty;
    t_smp              s_q_in, s_q_out;
    logic              s_wr_en;
    logic [IDX_W-1:0]  s_wr_idx;
    t_coef             s_wr_coef;
    logic [$clog2(Q_DEPTH+1)-1:0] s_q_cnt;

    bnca_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_item      (i_in_item),
        .o_full      (o_full),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (s_q_full),
        .i_q_empty   (s_q_empty),
        .o_q_push    (s_q_push),
        .o_q_data    (s_q_in),
        .o_wr_en     (s_wr_en),
        .o_wr_idx    (s_wr_idx),
        .o_wr_coef   (s_wr_coef)
    );

    bnca_fifo #(
        .T     (t_smp),
        .DEPTH (Q_DEPTH)
    ) u_smp_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_q_push),
        .i_data  (s_q_in),
        .o_full  (s_q_full),
        .o_empty (s_q_empty),
        .i_pop   (s_q_pop),
        .o_data  (s_q_out),
        .o_count (s_q_cnt)
    );

    bnca_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (s_q_empty),
        .i_q_data  (s_q_out),
        .o_q_pop   (s_q_pop),
        .i_wr_en   (s_wr_en),
        .i_wr_idx  (s_wr_idx),
        .i_wr_coef (s_wr_coef),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_item    (o_out_item)
    );

    a_q_count_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_q_empty |-> (s_q_cnt == '0))
        else $error("sample queue count mismatch");

endmodule
`default_nettype wire
